/* rtl/core/gns_pkg.sv */
// Shared types and constants for the grid neighbor search core.
package gns_pkg;

   localparam int MAX_AGENTS_DEF  = 64;
   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_ROWS_DEF    = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_MOVE  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_COLUMNS = 3'd0,
      CSR_ROWS    = 3'd1,
      CSR_HALF_W  = 3'd2,
      CSR_HALF_H  = 3'd3,
      CSR_CELL_X  = 3'd4,
      CSR_CELL_Y  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_WRITE,
      ST_ACK,
      ST_SCAN,
      ST_EMIT,
      ST_NONE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  agent_id;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [14:0] query_radius;
   } req_type;

   typedef struct packed {
      logic [5:0] neighbor_id;
      logic       found;
      logic       last;
   } rsp_type;

   // Cell divider control: start with operands, done with quotients.
   typedef struct packed {
      logic        start;
      logic [17:0] num0;
      logic [17:0] num1;
      logic [15:0] den0;
      logic [15:0] den1;
   } div_cmd_type;

endpackage

/* rtl/core/gns_if.sv */
// Valid/ready channel interface carrying a packed payload.
interface gns_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/gns_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module gns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/gns_div.sv */
// Two-lane restoring divider, one quotient bit per cycle per lane.
module gns_div
   import gns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output logic        done,
   output logic [17:0] quo0,
   output logic [17:0] quo1
);
   localparam int NW = 18;

   logic [NW-1:0] q0_ff, q1_ff, q0_in, q1_in;
   logic [NW:0]   r0_ff, r1_ff, r0_in, r1_in;
   logic [15:0]   d0_ff, d1_ff;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [NW:0]   t0, t1;

   always_comb begin
      t0 = {r0_ff[NW-1:0], q0_ff[NW-1]};
      t1 = {r1_ff[NW-1:0], q1_ff[NW-1]};
      q0_in = q0_ff; q1_in = q1_ff; r0_in = r0_ff; r1_in = r1_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (cmd.start) begin
         q0_in = cmd.num0; q1_in = cmd.num1;
         r0_in = '0; r1_in = '0;
         cnt_in = 5'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift in one numerator bit, subtract when it fits.
         if (t0 >= {3'b0, d0_ff}) begin
            r0_in = t0 - {3'b0, d0_ff}; q0_in = {q0_ff[NW-2:0], 1'b1};
         end else begin
            r0_in = t0; q0_in = {q0_ff[NW-2:0], 1'b0};
         end
         if (t1 >= {3'b0, d1_ff}) begin
            r1_in = t1 - {3'b0, d1_ff}; q1_in = {q1_ff[NW-2:0], 1'b1};
         end else begin
            r1_in = t1; q1_in = {q1_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in; q1_ff <= q1_in; r0_ff <= r0_in; r1_ff <= r1_in;
      if (cmd.start) begin
         d0_ff <= cmd.den0; d1_ff <= cmd.den1;
      end
   end

   assign done = done_ff;
   assign quo0 = q0_ff;
   assign quo1 = q1_ff;
endmodule

/* rtl/core/grid_neighbor_search_core.sv */
// Top level of the grid neighbor search core: control, agent table, scan.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | action, agent_id, pos_x, pos_y, query_radius
//  rsp     | out | valid/ready   | neighbor_id, found, last
//  csr     | in  | write enable  | index, data (no read-back)
//
// Add/move: accept, two divide passes (latch sums, start, 18 quotient bits, done),
// table write, ack.
// Query: accept, two divide passes, MAX_AGENTS table reads, then emit the final hit
// or a none-found response.
// The scan pauses whenever a response waits in the output register.
// Reset is synchronous; presence bits clear at once, no clearing pass.
module grid_neighbor_search_core
   import gns_pkg::*;
#(
   parameter int MAX_AGENTS  = MAX_AGENTS_DEF,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gns_if.sink                   req,
   gns_if.source                 rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   localparam int AW = $clog2(MAX_AGENTS);
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CELLW = CW + RW;
   localparam int MEMW = 32 + CELLW;

   // Configuration registers
   logic [4:0]  cols_ff, rows_ff;
   logic [14:0] hw_ff, hh_ff;
   logic [15:0] csx_ff, csy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 5'd16; rows_ff <= 5'd16;
         hw_ff <= 15'd16384; hh_ff <= 15'd16384;
         csx_ff <= 16'd2048; csy_ff <= 16'd2048;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMNS: cols_ff <= csr_write_data[4:0];
            CSR_ROWS:    rows_ff <= csr_write_data[4:0];
            CSR_HALF_W:  hw_ff <= csr_write_data[14:0];
            CSR_HALF_H:  hh_ff <= csr_write_data[14:0];
            CSR_CELL_X:  csx_ff <= csr_write_data;
            CSR_CELL_Y:  csy_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Cells in use, minus one (saturated counts)
   logic [6:0] ncol_m1, nrow_m1;
   always_comb begin
      if (cols_ff == 5'd0) ncol_m1 = '0;
      else if (32'(cols_ff) > MAX_COLUMNS) ncol_m1 = 7'(MAX_COLUMNS - 1);
      else ncol_m1 = 7'(cols_ff) - 7'd1;
      if (rows_ff == 5'd0) nrow_m1 = '0;
      else if (32'(rows_ff) > MAX_ROWS) nrow_m1 = 7'(MAX_ROWS - 1);
      else nrow_m1 = 7'(rows_ff) - 7'd1;
   end

   state_type state_ff, state_in;
   req_type   req_ff;
   logic      pass_ff, pass_in;        // 0: x axis, 1: y axis
   logic [17:0] s0_ff, s1_ff;          // offset coordinates for two lanes
   logic      pos0_ff, pos1_ff;        // offset coordinate is positive
   logic [6:0] lo_c_ff, hi_c_ff, lo_r_ff, hi_r_ff;
   logic [AW:0] rd_cnt_ff, rd_cnt_in;  // scan read address counter
   logic        rd_v_ff;               // table read data is valid
   logic [AW-1:0] rd_id_ff;
   logic        any_ff;
   logic [MAX_AGENTS-1:0] present_ff;
   logic        div_done;
   logic [17:0] quo0, quo1;
   div_cmd_type div_cmd;
   rsp_type     rsp_ff;
   logic        rsp_v_ff;

   // Offset sums for the current axis (lane 0: low/point, lane 1: high)
   logic signed [17:0] base, rad, sum0, sum1;
   logic [14:0] half;
   logic        is_query;
   assign is_query = (req_ff.action == ACT_QUERY);
   always_comb begin
      base = pass_ff ? 18'(signed'(req_ff.pos_y)) : 18'(signed'(req_ff.pos_x));
      half = pass_ff ? hh_ff : hw_ff;
      rad  = is_query ? signed'({3'b0, req_ff.query_radius}) : '0;
      sum0 = base - rad + signed'({3'b0, half});
      sum1 = base + rad + signed'({3'b0, half});
   end

   // Divide pass sequencing: latch the offset sums, start, then wait for done.
   logic sums_ready_ff, div_run_ff;
   logic latch_sums, start_div;
   assign latch_sums = (state_ff == ST_DIV) && !sums_ready_ff && !div_run_ff;
   assign start_div = (state_ff == ST_DIV) && sums_ready_ff && !div_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ready_ff <= 1'b0; div_run_ff <= 1'b0;
      end else begin
         sums_ready_ff <= latch_sums;
         if (start_div) div_run_ff <= 1'b1;
         else if (div_done) div_run_ff <= 1'b0;
      end
   end

   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.num0 = s0_ff;
      div_cmd.num1 = s1_ff;
      div_cmd.den0 = pass_ff ? ((csy_ff == 0) ? 16'd1 : csy_ff)
                             : ((csx_ff == 0) ? 16'd1 : csx_ff);
      div_cmd.den1 = div_cmd.den0;
      div_cmd.start = start_div;
   end

   gns_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .done(div_done),
      .quo0(quo0), .quo1(quo1));

   // Clamp quotient to the cells in use
   logic [6:0] lim, idx0, idx1;
   always_comb begin
      lim  = pass_ff ? nrow_m1 : ncol_m1;
      idx0 = !pos0_ff ? '0 : (quo0 > 18'(lim)) ? lim : quo0[6:0];
      idx1 = !pos1_ff ? '0 : (quo1 > 18'(lim)) ? lim : quo1[6:0];
   end

   logic rsp_free;
   assign rsp_free = !rsp_v_ff || rsp.ready;
   logic scan_go;
   assign scan_go = (state_ff == ST_SCAN) && rsp_free;

   // Agent table memory: pos_x, pos_y, cell
   logic mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [MEMW-1:0] mem_wd, mem_rd;
   assign mem_we = (state_ff == ST_WRITE) && (32'(req_ff.agent_id) < MAX_AGENTS) &&
      ((req_ff.action == ACT_ADD) ||
       (req_ff.action == ACT_MOVE && present_ff[AW'(req_ff.agent_id)]));
   assign mem_wa = AW'(req_ff.agent_id);
   assign mem_wd = {req_ff.pos_x, req_ff.pos_y, RW'(hi_r_ff), CW'(hi_c_ff)};
   // While the scan is paused, re-read the entry under evaluation
   assign mem_ra = scan_go ? rd_cnt_ff[AW-1:0] : rd_id_ff;

   gns_ram #(.WIDTH(MEMW), .DEPTH(MAX_AGENTS)) u_table (.clock(clock), .wr_en(mem_we),
      .wr_addr(mem_wa), .wr_data(mem_wd), .rd_addr(mem_ra), .rd_data(mem_rd));

   // Evaluate one read entry: presence, cell window, not same point, distance test
   logic signed [15:0] ex, ey;
   logic [CW-1:0] ec;
   logic [RW-1:0] er;
   assign {ex, ey, er, ec} = mem_rd;
   logic signed [16:0] dx, dy;
   logic [15:0] adx, ady;
   logic [31:0] sqx, sqy;
   logic [33:0] d2;
   logic [29:0] r2;
   logic hit;
   always_comb begin
      dx = 17'(ex) - 17'(signed'(req_ff.pos_x));
      dy = 17'(ey) - 17'(signed'(req_ff.pos_y));
      adx = dx[16] ? 16'(-dx) : 16'(dx);
      ady = dy[16] ? 16'(-dy) : 16'(dy);
      sqx = 32'(adx) * 32'(adx);
      sqy = 32'(ady) * 32'(ady);
      d2 = 34'(sqx) + 34'(sqy);
      r2 = 30'(req_ff.query_radius) * 30'(req_ff.query_radius);
      hit = present_ff[rd_id_ff] &&
            7'(ec) >= lo_c_ff && 7'(ec) <= hi_c_ff &&
            7'(er) >= lo_r_ff && 7'(er) <= hi_r_ff &&
            !(ex == signed'(req_ff.pos_x) && ey == signed'(req_ff.pos_y)) &&
            d2 < 34'(r2);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) begin
            state_in = (req.payload.action == ACT_QUERY || req.payload.action == ACT_ADD ||
                        req.payload.action == ACT_MOVE) ? ST_DIV : ST_ACK;
            pass_in = 1'b0;
         end
         ST_DIV: if (div_done) begin
            if (!pass_ff) pass_in = 1'b1;
            else state_in = is_query ? ST_SCAN : ST_WRITE;
         end
         ST_WRITE: state_in = ST_ACK;
         ST_ACK: if (rsp_free) state_in = ST_IDLE;
         ST_SCAN: if (scan_go && rd_cnt_ff == (AW+1)'(MAX_AGENTS) && !rd_v_ff)
            state_in = any_ff ? ST_EMIT : ST_NONE;
         ST_EMIT: if (rsp_free) state_in = ST_IDLE;
         ST_NONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   // Scan read counter: reads advance only when the output can take a hit
   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (state_ff == ST_DIV && div_done && pass_ff && is_query) rd_cnt_in = '0;
      else if (scan_go && rd_cnt_ff < (AW+1)'(MAX_AGENTS)) rd_cnt_in = rd_cnt_ff + 1'b1;
      else if (state_ff == ST_IDLE) rd_cnt_in = '1;
   end

   // A found agent is held one step: the final one gets last set at scan end.
   logic        hold_v_ff;
   logic [AW-1:0] hold_id_ff;

   // Output register load: held hit, acknowledge or none found, final hit
   logic    rsp_load;
   rsp_type rsp_load_val;
   always_comb begin
      rsp_load = 1'b0;
      rsp_load_val = rsp_ff;
      if (scan_go && rd_v_ff && hit && hold_v_ff) begin
         rsp_load = 1'b1;
         rsp_load_val = '{neighbor_id: 6'(hold_id_ff), found: 1'b1, last: 1'b0};
      end
      if ((state_ff == ST_ACK || state_ff == ST_NONE) && rsp_free) begin
         rsp_load = 1'b1;
         rsp_load_val = '{neighbor_id: 6'd0, found: 1'b0, last: 1'b1};
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_load = 1'b1;
         rsp_load_val = '{neighbor_id: 6'(hold_id_ff), found: 1'b1, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pass_ff <= 1'b0; rd_cnt_ff <= '1; rd_v_ff <= 1'b0;
         present_ff <= '0; rsp_v_ff <= 1'b0; any_ff <= 1'b0; hold_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pass_ff <= pass_in; rd_cnt_ff <= rd_cnt_in;
         // Read data stays valid while the scan is paused
         if (scan_go) rd_v_ff <= rd_cnt_ff < (AW+1)'(MAX_AGENTS);
         else if (state_ff != ST_SCAN) rd_v_ff <= 1'b0;
         if (mem_we) present_ff[mem_wa] <= 1'b1;
         if (state_ff == ST_IDLE) begin
            any_ff <= 1'b0; hold_v_ff <= 1'b0;
         end
         // Scan hit: keep the new one, the previous one goes out
         if (scan_go && rd_v_ff && hit) begin
            any_ff <= 1'b1;
            hold_v_ff <= 1'b1;
            hold_id_ff <= rd_id_ff;
         end
         if (rsp_load) begin
            rsp_v_ff <= 1'b1;
            rsp_ff <= rsp_load_val;
         end else if (rsp_v_ff && rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
      if (scan_go) rd_id_ff <= rd_cnt_ff[AW-1:0];
      if (req.valid && req.ready) req_ff <= req.payload;
      // Latch offset sums for the current axis before its divide pass
      if (latch_sums) begin
         s0_ff <= 18'(unsigned'(sum0)); s1_ff <= 18'(unsigned'(sum1));
         pos0_ff <= (sum0 > 0); pos1_ff <= (sum1 > 0);
      end
      if (state_ff == ST_DIV && div_done) begin
         if (!pass_ff) begin
            lo_c_ff <= idx0; hi_c_ff <= idx1;
         end else begin
            lo_r_ff <= idx0; hi_r_ff <= idx1;
         end
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.payload = rsp_ff;
endmodule
